FILE: src/ost_pkg.sv
`timescale 1ns / 1ps

package ost_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_FIND = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	typedef struct packed {
		op_t                operation;
		logic signed [31:0] value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] element;
		logic [6:0]         count;
		logic               empty_res;
	} rsp_t;

	typedef struct packed {
		logic             cmp;
		logic             shift;
		logic             wr;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

FILE: src/ost_cell.sv
`timescale 1ns / 1ps

module ost_cell
	import ost_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [IDX_W-1:0]   slot,
	input  logic [CNT_W-1:0]   count,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	input  logic [31:0]        next_entry,
	output logic [31:0]        entry,
	output logic               hit,
	output logic [31:0]        rd_data
);

	logic [31:0] entry_q;
	logic        hit_q;
	logic [31:0] rd_q;
	logic        in_use;
	logic        sel;

	assign in_use = {1'b0, slot} < count;
	assign sel    = IDX_W'(position) == slot;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_q <= in_use && (entry_q == value);
			rd_q  <= sel ? entry_q : '0;
		end
		if (ctl.shift && (slot >= ctl.idx)) begin
			entry_q <= next_entry;
		end else if (ctl.wr && (slot == count[IDX_W-1:0])) begin
			entry_q <= value;
		end
	end

	assign entry   = entry_q;
	assign hit     = hit_q;
	assign rd_data = rd_q;

endmodule

FILE: src/ordered_set_table.sv
`timescale 1ns / 1ps
// Ordered set of up to 64 distinct signed 32-bit values kept in insertion order.
// A request transfer on req carries an operation (add, delete, find or read), a
// value and a read position. Each request produces exactly one transfer on rsp
// with a status, the element read, the element count after the request and an
// empty flag. Deletes close the gap so the remaining order is kept.
// The entries live in a row of cells. In the compare state after a request is
// taken every cell compares its entry with the value and latches its read data;
// in the update state the hit index is encoded and, once the output register
// is free, the cells shift down or take an appended value and the result is
// loaded into the output register. A new request is taken in the cycle the
// result is loaded, so no request is taken while an earlier one is in flight.
// When rsp_stall is high the result is held; the current request waits in the
// update state and req stays stalled until the output register can take it.
// Reset empties the set and clears rsp_valid; entry contents are not cleared.
module ordered_set_table
	import ost_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	state_t           state_q, state_nxt;
	req_t             req_q;
	rsp_t             rsp_q, res;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic             out_free;
	logic             upd_go;
	logic             take;
	logic             hit_any;
	logic [IDX_W-1:0] hit_idx;
	logic [31:0]      rd_all;
	logic             add_ok, del_ok;
	cell_ctl_t        ctl;

	logic [CAPACITY-1:0] hit;
	logic [31:0]         entry [CAPACITY];
	logic [31:0]         rd    [CAPACITY];

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign take     = req_valid && !req_stall;

	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		upd_go    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				state_nxt = S_UPD;
			end
			S_UPD: begin
				if (out_free) begin
					upd_go    = 1'b1;
					req_stall = 1'b0;
					state_nxt = req_valid ? S_CMP : S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= req;
		end
	end

	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		rd_all  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_any = hit_any | hit[i];
			if (hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			rd_all = rd_all | rd[i];
		end
	end

	assign add_ok = (req_q.operation == OP_ADD) && !hit_any && (count_q < CNT_W'(CAPACITY));
	assign del_ok = (req_q.operation == OP_DEL) && hit_any;

	always_comb begin
		ctl.cmp   = (state_q == S_CMP);
		ctl.shift = upd_go && del_ok;
		ctl.wr    = upd_go && add_ok;
		ctl.idx   = hit_idx;
	end

	always_comb begin
		count_nxt = count_q;
		if (add_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		res         = '0;
		res.status  = ST_OK;
		unique case (req_q.operation)
			OP_ADD: begin
				if (hit_any) begin
					res.status = ST_MISS;
				end else if (!add_ok) begin
					res.status = ST_FULL;
				end
			end
			OP_DEL, OP_FIND: begin
				res.status = hit_any ? ST_OK : ST_MISS;
			end
			OP_READ: begin
				if (CNT_W'(req_q.position) < count_q) begin
					res.element = rd_all;
				end else begin
					res.status = ST_RANGE;
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
		res.count     = 7'(count_nxt);
		res.empty_res = (count_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] nbr;
		if (i == CAPACITY - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = entry[i+1];
		end
		ost_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.slot       (IDX_W'(i)),
			.count      (count_q),
			.value      (req_q.value),
			.position   (req_q.position),
			.next_entry (nbr),
			.entry      (entry[i]),
			.hit        (hit[i]),
			.rd_data    (rd[i])
		);
	end

`ifndef NO_ASSERTIONS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $onehot0(hit))
		else $error("more than one cell matched the value");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go && add_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("add did not grow the count");

	a_take_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q == S_CMP)
		else $error("request transfer not followed by compare");

	a_upd_result: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> rsp_valid)
		else $error("update without result");
`endif

endmodule
